/* rtl/clns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types, constants and the step table of the character-LCD sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

    localparam int LINE_LENGTH = 16;
    localparam int CNT_W       = $clog2(2 * LINE_LENGTH + 1);
    localparam int STEP_W      = 4;
    localparam int MASK_W      = 16;
    localparam int PADDR_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_PRINT = 2'd1;
    localparam logic [1:0] KIND_GOTO  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] REG_ENABLE_HOLD = 2'd0;
    localparam logic [1:0] REG_CMD_SETTLE  = 2'd1;
    localparam logic [1:0] REG_PAGE_PAUSE  = 2'd2;

    localparam logic [16:0] ENABLE_HOLD_RST = 17'd10000;
    localparam logic [16:0] CMD_SETTLE_RST  = 17'd2000;
    localparam logic [19:0] PAGE_PAUSE_RST  = 20'd500000;

    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_HOME     = 8'h80;
    localparam logic [7:0] CMD_ROW1     = 8'hC0;

    localparam logic [3:0] WAKE_NIB  = 4'h3;
    localparam logic [3:0] MODE4_NIB = 4'h2;
    localparam logic [19:0] WAKE_LONG_US  = 20'd5000;
    localparam logic [19:0] WAKE_SHORT_US = 20'd150;

    // print step positions
    localparam logic [STEP_W-1:0] PS_NS_HI    = 4'd0;
    localparam logic [STEP_W-1:0] PS_NS_LO    = 4'd1;
    localparam logic [STEP_W-1:0] PS_ROW_HI   = 4'd2;
    localparam logic [STEP_W-1:0] PS_ROW_LO   = 4'd3;
    localparam logic [STEP_W-1:0] PS_PAUSE    = 4'd4;
    localparam logic [STEP_W-1:0] PS_CLR_HI   = 4'd5;
    localparam logic [STEP_W-1:0] PS_CLR_LO   = 4'd6;
    localparam logic [STEP_W-1:0] PS_HOME_HI  = 4'd7;
    localparam logic [STEP_W-1:0] PS_HOME_LO  = 4'd8;
    localparam logic [STEP_W-1:0] PS_CHAR_HI  = 4'd9;
    localparam logic [STEP_W-1:0] PS_CHAR_LO  = 4'd10;
    localparam logic [STEP_W-1:0] GS_ERROR    = 4'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        character;
        logic [7:0]        addr;
        logic [MASK_W-1:0] mask;
    } t_desc;

    typedef struct packed {
        logic [16:0] cmd_settle_us;
        logic [19:0] page_pause_us;
    } t_cfg;

    typedef struct packed {
        logic        is_wait;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [19:0] wait_us;
        logic        last;
        logic        status;
    } t_result;

    function automatic logic [7:0] f_init_cmd(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CMD_FUNC_SET;
            3'd1:    b = CMD_DISP_OFF;
            3'd2:    b = CMD_CLEAR;
            3'd3:    b = CMD_ENTRY;
            3'd4:    b = CMD_DISP_ON;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

    function automatic t_result f_step(input t_desc d, input logic [STEP_W-1:0] s,
                                       input t_cfg cfg);
        t_result    r;
        logic [7:0] b;
        r = '0;
        b = '0;
        case (d.kind)
            KIND_INIT: begin
                if (s < 4'd4) begin
                    r.nibble  = (s == 4'd3) ? MODE4_NIB : WAKE_NIB;
                    r.wait_us = (s == 4'd0) ? WAKE_LONG_US : WAKE_SHORT_US;
                end else begin
                    b         = f_init_cmd(3'((s - 4'd4) >> 1));
                    r.nibble  = s[0] ? b[3:0] : b[7:4];
                    r.wait_us = s[0] ? 20'(cfg.cmd_settle_us) : 20'd0;
                end
            end
            KIND_PRINT: begin
                case (s)
                    PS_NS_HI:   r.nibble = CMD_CLEAR[7:4];
                    PS_NS_LO:   r.nibble = CMD_CLEAR[3:0];
                    PS_ROW_HI:  r.nibble = CMD_ROW1[7:4];
                    PS_ROW_LO:  r.nibble = CMD_ROW1[3:0];
                    PS_PAUSE: begin
                        r.is_wait = 1'b1;
                        r.wait_us = cfg.page_pause_us;
                    end
                    PS_CLR_HI:  r.nibble = CMD_CLEAR[7:4];
                    PS_CLR_LO:  r.nibble = CMD_CLEAR[3:0];
                    PS_HOME_HI: r.nibble = CMD_HOME[7:4];
                    PS_HOME_LO: r.nibble = CMD_HOME[3:0];
                    PS_CHAR_HI: begin
                        r.reg_select = 1'b1;
                        r.nibble     = d.character[7:4];
                    end
                    PS_CHAR_LO: begin
                        r.reg_select = 1'b1;
                        r.nibble     = d.character[3:0];
                    end
                    default:    r = '0;
                endcase
            end
            KIND_GOTO: begin
                if (s == GS_ERROR) begin
                    r.is_wait = 1'b1;
                    r.status  = 1'b1;
                end else begin
                    r.nibble = s[0] ? d.addr[3:0] : d.addr[7:4];
                end
            end
            default: begin
                r.nibble = s[0] ? CMD_CLEAR[3:0] : CMD_CLEAR[7:4];
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/char_lcd_nibble_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top
// 4-bit character-LCD sequencer: requests in, nibble strobes and waits out.
// ----------------------------------------------------------------------------
// Request beats (init, print, go-to, clear) enter on i_valid/o_ready. Each
// request expands into 1 to 16 result beats on o_valid/i_ready; o_last
// marks the final beat of a request, o_status flags an invalid go-to.
// Timing settings sit behind the APB port (bytes 0x0, 0x4, 0x8).
// When the back end is idle, the first result of a request passes through
// the queue, the descriptor register and the output register. The back end
// emits one result per cycle while the receiver does not stall, and a
// 4-entry request queue lets requests be taken while earlier ones are still
// being expanded. Sustained rate is one result beat per cycle when the
// receiver does not stall, set by the single step sequencer in the back end.
// When the receiver stalls, the output register holds its beat, the back
// end stops, and the queue fills; o_ready drops once four requests wait.
// Reset empties the queue, drops o_valid, zeroes the character index and
// loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_top
    import clns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_character,
    input  logic               i_new_string,
    input  logic [4:0]         i_column,
    input  logic [1:0]         i_row,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_is_wait,
    output logic               o_reg_select,
    output logic [3:0]         o_nibble,
    output logic [19:0]        o_wait_us,
    output logic               o_last,
    output logic               o_status
);

    t_cfg  cfg;
    t_desc push_desc;
    t_desc q_desc;
    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;

    clns_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clns_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_character  (i_character),
        .i_new_string (i_new_string),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_push       (push),
        .o_desc       (push_desc),
        .i_q_ready    (q_ready)
    );

    clns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    clns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_desc     (q_desc),
        .o_q_pop      (q_pop),
        .i_cfg        (cfg),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_is_wait    (o_is_wait),
        .o_reg_select (o_reg_select),
        .o_nibble     (o_nibble),
        .o_wait_us    (o_wait_us),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule

/* rtl/clns_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_regs
// APB-style register file holding the timing settings.
// ----------------------------------------------------------------------------
module clns_regs
    import clns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [16:0] r_enable_hold;
    logic [16:0] r_cmd_settle;
    logic [19:0] r_page_pause;
    logic        wr_en;
    logic [1:0]  idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_hold <= ENABLE_HOLD_RST;
            r_cmd_settle  <= CMD_SETTLE_RST;
            r_page_pause  <= PAGE_PAUSE_RST;
        end else if (wr_en) begin
            case (idx)
                REG_ENABLE_HOLD: r_enable_hold <= pwdata[16:0];
                REG_CMD_SETTLE:  r_cmd_settle  <= pwdata[16:0];
                REG_PAGE_PAUSE:  r_page_pause  <= pwdata[19:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ENABLE_HOLD: prdata = 32'(r_enable_hold);
            REG_CMD_SETTLE:  prdata = 32'(r_cmd_settle);
            REG_PAGE_PAUSE:  prdata = 32'(r_page_pause);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.cmd_settle_us = r_cmd_settle;
    assign o_cfg.page_pause_us = r_page_pause;

endmodule

/* rtl/clns_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_front
// Accepts requests, tracks the character index and builds step descriptors.
// ----------------------------------------------------------------------------
module clns_front
    import clns_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_character,
    input  logic       i_new_string,
    input  logic [4:0] i_column,
    input  logic [1:0] i_row,
    output logic       o_push,
    output t_desc      o_desc,
    input  logic       i_q_ready
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] base;
    logic             row_wrap;
    logic             page_wrap;
    logic             goto_err;
    logic             accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign o_push  = accept;

    always_comb begin
        base      = i_new_string ? '0 : r_count;
        row_wrap  = (base == CNT_W'(LINE_LENGTH));
        page_wrap = (base >= CNT_W'(2 * LINE_LENGTH));
        n_count   = (page_wrap ? '0 : base) + CNT_W'(1);
        goto_err  = (32'(i_column) >= 32'(LINE_LENGTH)) || (i_row > 2'd1);

        o_desc.kind      = i_command;
        o_desc.character = i_character;
        o_desc.addr      = {1'b1, i_row[0], 1'b0, i_column};
        o_desc.mask      = '0;
        case (i_command)
            KIND_INIT: o_desc.mask = '1;
            KIND_PRINT: begin
                o_desc.mask[PS_NS_HI]   = i_new_string;
                o_desc.mask[PS_NS_LO]   = i_new_string;
                o_desc.mask[PS_ROW_HI]  = row_wrap;
                o_desc.mask[PS_ROW_LO]  = row_wrap;
                o_desc.mask[PS_PAUSE]   = page_wrap;
                o_desc.mask[PS_CLR_HI]  = page_wrap;
                o_desc.mask[PS_CLR_LO]  = page_wrap;
                o_desc.mask[PS_HOME_HI] = page_wrap;
                o_desc.mask[PS_HOME_LO] = page_wrap;
                o_desc.mask[PS_CHAR_HI] = 1'b1;
                o_desc.mask[PS_CHAR_LO] = 1'b1;
            end
            KIND_GOTO: begin
                o_desc.mask[0]        = !goto_err;
                o_desc.mask[1]        = !goto_err;
                o_desc.mask[GS_ERROR] = goto_err;
            end
            default: o_desc.mask[1:0] = 2'b11;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept && i_command == KIND_PRINT) begin
            r_count <= n_count;
        end
    end

endmodule

/* rtl/clns_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_queue
// Small descriptor FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module clns_queue
    import clns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/clns_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_back
// Walks the step mask of each descriptor and emits one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module clns_back
    import clns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_desc       i_q_desc,
    output logic        o_q_pop,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_wait,
    output logic        o_reg_select,
    output logic [3:0]  o_nibble,
    output logic [19:0] o_wait_us,
    output logic        o_last,
    output logic        o_status
);

    logic              r_busy;
    t_desc             r_desc;
    logic [MASK_W-1:0] r_mask;
    logic              r_out_valid;
    t_result           r_out;

    logic [STEP_W-1:0] step;
    logic              is_last;
    logic              can_emit;
    logic              emit;
    logic              load;
    t_result           res;

    always_comb begin
        step = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                step = STEP_W'(i);
            end
        end
    end

    assign is_last  = ((r_mask & (r_mask - MASK_W'(1))) == '0);
    assign can_emit = !r_out_valid || i_ready;
    assign emit     = r_busy && can_emit;
    assign load     = i_q_valid && (!r_busy || (emit && is_last));
    assign o_q_pop  = load;

    always_comb begin
        res      = f_step(r_desc, step, i_cfg);
        res.last = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_q_desc;
            r_mask <= i_q_desc.mask;
        end else if (emit) begin
            r_mask <= r_mask & ~(MASK_W'(1) << step);
        end
        if (emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_wait    = r_out.is_wait;
    assign o_reg_select = r_out.reg_select;
    assign o_nibble     = r_out.nibble;
    assign o_wait_us    = r_out.wait_us;
    assign o_last       = r_out.last;
    assign o_status     = r_out.status;

    a_busy_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("busy with empty step mask");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop from empty queue");

    a_error_is_lone_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_is_wait && o_last && o_nibble == 4'd0))
        else $error("error result malformed");

    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_busy) |-> (emit && is_last))
        else $error("descriptor loaded over unfinished work");

endmodule

/* dv/tb_char_lcd_nibble_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer_top
// Self-checking bench for the 4-bit character-LCD nibble sequencer.
// ----------------------------------------------------------------------------
// Requests go in on the valid/ready request channel with random gaps. The
// result channel is back-pressured at random. The bench expands each accepted
// request into the nibble strobes and waits it should produce, using its own
// copy of the character index and the timing registers. It then checks every
// result beat against that list, field by field. The timing registers are
// written over APB between phases and read back. The phases cover the range
// ends and over-wide values. Random text runs long enough to wrap onto row 1
// and to overflow the page.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_top;
    import clns_pkg::*;

    localparam logic [47:0] INIT_CMD_SEQ = {CMD_FUNC_SET, CMD_DISP_OFF, CMD_CLEAR,
                                            CMD_ENTRY, CMD_DISP_ON, CMD_CLEAR};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_command;
    logic [7:0]         i_character;
    logic               i_new_string;
    logic [4:0]         i_column;
    logic [1:0]         i_row;
    logic               o_valid;
    logic               i_ready;
    logic               o_is_wait;
    logic               o_reg_select;
    logic [3:0]         o_nibble;
    logic [19:0]        o_wait_us;
    logic               o_last;
    logic               o_status;

    logic [16:0] hold_us   = ENABLE_HOLD_RST;
    logic [16:0] settle_us = CMD_SETTLE_RST;
    logic [19:0] pause_us  = PAGE_PAUSE_RST;
    logic [7:0]  char_idx  = 8'd0;
    int          page_turns     = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          fault_count    = 0;

    t_result req_beats[$];
    t_result due_beats[$];

    char_lcd_nibble_sequencer_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic void add_beat(logic w, logic rs, logic [3:0] nib, logic [19:0] us,
                                     logic st);
        t_result r;
        r            = '0;
        r.is_wait    = w;
        r.reg_select = rs;
        r.nibble     = nib;
        r.wait_us    = us;
        r.status     = st;
        req_beats.push_back(r);
    endfunction

    function automatic void add_byte(logic rs, logic [7:0] b, logic [19:0] us);
        add_beat(1'b0, rs, b[7:4], 20'd0, 1'b0);
        add_beat(1'b0, rs, b[3:0], us, 1'b0);
    endfunction

    function automatic void expand_request(logic [1:0] cmd, logic [7:0] ch, logic ns,
                                           logic [4:0] col, logic [1:0] row);
        logic [7:0] addr;
        int         i;
        req_beats.delete();
        case (cmd)
            KIND_INIT: begin
                for (i = 0; i < 4; i++) begin
                    add_beat(1'b0, 1'b0, (i == 3) ? MODE4_NIB : WAKE_NIB,
                             (i == 0) ? WAKE_LONG_US : WAKE_SHORT_US, 1'b0);
                end
                for (i = 0; i < 6; i++) begin
                    add_byte(1'b0, INIT_CMD_SEQ[47 - 8 * i -: 8], {3'd0, settle_us});
                end
            end
            KIND_PRINT: begin
                if (ns) begin
                    add_byte(1'b0, CMD_CLEAR, 20'd0);
                    char_idx = 8'd0;
                end
                if (char_idx == LINE_LENGTH) begin
                    add_byte(1'b0, CMD_ROW1, 20'd0);
                end else if (char_idx >= 2 * LINE_LENGTH) begin
                    add_beat(1'b1, 1'b0, 4'h0, pause_us, 1'b0);
                    add_byte(1'b0, CMD_CLEAR, 20'd0);
                    add_byte(1'b0, CMD_HOME, 20'd0);
                    char_idx = 8'd0;
                    page_turns++;
                end
                add_byte(1'b1, ch, 20'd0);
                char_idx = char_idx + 8'd1;
            end
            KIND_GOTO: begin
                if (col >= LINE_LENGTH || row > 2'd1) begin
                    add_beat(1'b1, 1'b0, 4'h0, 20'd0, 1'b1);
                end else begin
                    addr = CMD_HOME + {1'b0, row[0], 6'd0} + {3'd0, col};
                    add_byte(1'b0, addr, 20'd0);
                end
            end
            default: begin
                add_byte(1'b0, CMD_CLEAR, 20'd0);
            end
        endcase
        req_beats[req_beats.size() - 1].last = 1'b1;
        foreach (req_beats[k]) due_beats.push_back(req_beats[k]);
    endfunction

    function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual nibble %0h wait %0d",
                         $time, o_nibble, o_wait_us);
                fault_count++;
            end else begin
                want = due_beats.pop_front();
                check_field("is_wait", want.is_wait, o_is_wait);
                check_field("reg_select", want.reg_select, o_reg_select);
                check_field("nibble", want.nibble, o_nibble);
                check_field("wait_us", want.wait_us, o_wait_us);
                check_field("last", want.last, o_last);
                check_field("status", want.status, o_status);
            end
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // entered and left at a falling edge
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch, input logic ns,
                                input logic [4:0] col, input logic [1:0] row);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_command    = cmd;
        i_character  = ch;
        i_new_string = ns;
        i_column     = col;
        i_row        = row;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expand_request(cmd, ch, ns, col, row);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid = 1'b0;
        while (due_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timing(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] want;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        case (idx)
            REG_ENABLE_HOLD: begin
                hold_us = value[16:0];
                want    = {15'd0, hold_us};
            end
            REG_CMD_SETTLE: begin
                settle_us = value[16:0];
                want      = {15'd0, settle_us};
            end
            default: begin
                pause_us = value[19:0];
                want     = {12'd0, pause_us};
            end
        endcase
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== want) begin
            $display("%0t: register %0d readback, expected %0h actual %0h",
                     $time, idx, want, readback);
            fault_count++;
        end
    endtask

    task automatic set_phase(input logic [31:0] hold, input logic [31:0] settle,
                             input logic [31:0] pause, input int src_pct, input int sink_pct);
        wait_drain();
        write_timing(REG_ENABLE_HOLD, hold);
        write_timing(REG_CMD_SETTLE, settle);
        write_timing(REG_PAGE_PAUSE, pause);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic test_init_sequence();
        send_request(KIND_INIT, 8'($urandom), 1'($urandom), 5'($urandom), 2'($urandom));
    endtask

    task automatic test_clear_display();
        send_request(KIND_CLEAR, 8'hFF, 1'b1, 5'd31, 2'd3);
        send_request(KIND_CLEAR, 8'h00, 1'b0, 5'd0, 2'd0);
    endtask

    task automatic test_goto_positions();
        send_request(KIND_GOTO, 8'h00, 1'b0, 5'd0, 2'd0);
        send_request(KIND_GOTO, 8'hFF, 1'b1, 5'd15, 2'd1);
        send_request(KIND_GOTO, 8'h00, 1'b0, 5'd16, 2'd0);
        send_request(KIND_GOTO, 8'h00, 1'b0, 5'd31, 2'd3);
        send_request(KIND_GOTO, 8'h00, 1'b0, 5'd0, 2'd2);
        send_request(KIND_GOTO, 8'h00, 1'b0, 5'd9, 2'd1);
    endtask

    task automatic test_print_edges();
        send_request(KIND_PRINT, 8'h00, 1'b1, 5'd0, 2'd0);
        send_request(KIND_PRINT, 8'hFF, 1'b0, 5'd31, 2'd3);
        send_request(KIND_PRINT, 8'hA5, 1'b0, 5'd0, 2'd0);
        send_request(KIND_PRINT, 8'h5A, 1'b1, 5'd0, 2'd0);
    endtask

    // mostly text; with need_turn set, runs on until the page has overflowed
    task automatic test_text_stream(input int min_items, input bit need_turn);
        int         sent;
        int         turns0;
        int         pick;
        logic [4:0] col;
        logic [1:0] row;
        sent   = 0;
        turns0 = page_turns;
        while (sent < min_items || (need_turn && page_turns == turns0)) begin
            pick = $urandom_range(0, 99);
            col  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(16, 31))
                                               : 5'($urandom_range(0, 15));
            row  = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
            if (pick < 8) begin
                send_request(KIND_GOTO, 8'($urandom), 1'($urandom), col, row);
            end else if (pick < 13) begin
                send_request(KIND_CLEAR, 8'($urandom), 1'($urandom), col, row);
            end else if (pick < 15) begin
                test_init_sequence();
            end else begin
                send_request(KIND_PRINT, 8'($urandom), $urandom_range(0, 39) == 0, col, row);
            end
            sent++;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_valid      = 1'b0;
        i_command    = KIND_INIT;
        i_character  = '0;
        i_new_string = 1'b0;
        i_column     = '0;
        i_row        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_init_sequence();
        test_clear_display();
        test_goto_positions();
        test_print_edges();
        test_text_stream(20, 1'b1);

        set_phase(32'd1, 32'd0, 32'd0, 58, 0);
        test_init_sequence();
        test_text_stream(12, 1'b0);

        set_phase(32'd100000, 32'd100000, 32'd1000000, 0, 58);
        test_init_sequence();
        test_text_stream(12, 1'b0);

        set_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30, 30);
        test_init_sequence();
        test_text_stream(12, 1'b0);

        wait_drain();
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
